[design/assert_macros.svh]
// Assertion macros shared by the hasher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/sha_pkg.sv]
// Types, constants and round functions for the SHA-256 hasher.
package sha_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        digest_last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take the input word
    logic pad;        // write one padding word
    logic len;        // write the two length words
    logic init_vars;  // copy chain value into working variables
    logic round;      // one compression round
    logic fold;       // add working variables into the chain value
    logic emit;       // shift out one digest word
    logic reinit;     // restore the initial hash and clear counts
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       block_full;  // pending bytes fill the block
    logic       pad_done;    // padding reached the length field
    logic       two_blocks;  // length field does not fit after the pad byte
    logic [5:0] round_idx;
    logic [2:0] emit_idx;
  } dp_sts_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[design/sha256_message_hasher.sv]
// Top level of the SHA-256 message hasher.
//   channel | ports                          | handshake
//   input   | start, busy, in_item           | accepted when start && !busy
//   result  | out_valid, out_item            | each word strobed once, no back-pressure
// An item that is not last and leaves the block short of 64 bytes leaves busy low.
// An item that fills the block holds busy through setup, 64 rounds and fold.
// The last item then pads one word per cycle until a check finds the padding done,
// writes the length, runs one or two compressions and emits h0..h7 in order.
// Reset is synchronous; it restores the initial hash and clears the counts.
module sha256_message_hasher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sha_pkg::in_item_t  in_item,
  output logic               out_valid,
  output sha_pkg::out_item_t out_item
);

  sha_pkg::dp_cmd_t cmd;
  sha_pkg::dp_sts_t sts;

  sha_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_last (in_item.last),
    .busy    (busy),
    .cmd     (cmd),
    .sts     (sts)
  );

  sha_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[design/sha_ctrl.sv]
// Controller state machine for the SHA-256 hasher.
`include "assert_macros.svh"
module sha_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_last,
  output logic             busy,
  output sha_pkg::dp_cmd_t cmd,
  input  sha_pkg::dp_sts_t sts
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PAD   = 7'b0000010,
    ST_LEN   = 7'b0000100,
    ST_INIT  = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_FOLD  = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;     // message ends after this block
  logic   final_r, final_nxt; // current block carries the length

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      final_r <= final_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    final_nxt = final_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          fin_nxt   = in_last;
          final_nxt = 1'b0;
          // Padding is handled after any full block is compressed.
          if (sts.block_full) begin
            state_nxt = ST_INIT;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (sts.pad_done) begin
          if (sts.two_blocks) begin
            state_nxt = ST_INIT;
          end else begin
            state_nxt = ST_LEN;
          end
        end else begin
          cmd.pad = 1'b1;
        end
      end
      ST_LEN: begin
        cmd.len   = 1'b1;
        final_nxt = 1'b1;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init_vars = 1'b1;
        state_nxt     = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_idx == 6'd63) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (final_r) begin
          state_nxt = ST_EMIT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.emit_idx == 3'd7) begin
          cmd.reinit = 1'b1;
          fin_nxt    = 1'b0;
          final_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_NEXT(a_emit_follows_fold, clk, rst_n, cmd.fold && final_r, state_r == ST_EMIT, "emit must follow final fold")
  `ASSERT_ALWAYS(a_len_once, clk, rst_n, !(cmd.len && final_r), "length written twice")
  `ASSERT_NEXT(a_emit_ends_idle, clk, rst_n, cmd.emit && sts.emit_idx == 3'd7, state_r == ST_IDLE, "no idle after emit")

endmodule

[design/sha_dp.sv]
// Datapath of the SHA-256 hasher: byte packing, schedule, rounds, chain value.
`include "assert_macros.svh"
module sha_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sha_pkg::in_item_t  in_item,
  input  sha_pkg::dp_cmd_t   cmd,
  output sha_pkg::dp_sts_t   sts,
  output logic               out_valid,
  output sha_pkg::out_item_t out_item
);

  logic [31:0] chain_r [8];
  logic [31:0] var_r [8];
  logic [31:0] w_r [16];       // rolling schedule window
  logic [60:0] total_r;
  logic [5:0]  fill_r;         // bytes held, 0..63
  logic        full_r;         // padding has filled the block, awaiting compression
  logic [5:0]  rnd_r;
  logic [2:0]  emit_r;
  logic        out_valid_r;
  logic [32:0] out_r;
  logic [31:0] spill_r;        // bytes of a transaction that run past a full block
  // Marks that the 0x80 byte has already been placed for this message.
  logic        total_pad_r;

  logic [2:0]  cnt;
  logic [6:0]  fill_sum;
  logic [63:0] bits;
  logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;

  assign cnt      = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
  assign fill_sum = {1'b0, fill_r} + {4'd0, cnt};
  assign bits     = {total_r, 3'b000};

  assign s0    = sha_pkg::rotr(w_r[1], 7) ^ sha_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
  assign s1    = sha_pkg::rotr(w_r[14], 17) ^ sha_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
  assign w_new = s1 + w_r[9] + s0 + w_r[0];
  assign big1  = sha_pkg::rotr(var_r[4], 6) ^ sha_pkg::rotr(var_r[4], 11)
               ^ sha_pkg::rotr(var_r[4], 25);
  assign ch    = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
  assign t1    = var_r[7] + big1 + ch + sha_pkg::ROUND_K[rnd_r] + w_r[0];
  assign big0  = sha_pkg::rotr(var_r[0], 2) ^ sha_pkg::rotr(var_r[0], 13)
               ^ sha_pkg::rotr(var_r[0], 22);
  assign maj   = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
  assign t2    = big0 + maj;

  // Padding is done only after the 0x80 byte is in place.
  assign sts.block_full = fill_sum[6];
  assign sts.pad_done   = total_pad_r && (full_r || fill_r == 6'd56);
  assign sts.two_blocks = full_r;
  assign sts.round_idx  = rnd_r;
  assign sts.emit_idx   = emit_r;

  // Byte packing: the pending word of a partial item is merged byte by byte.
  function automatic logic [31:0] merge(input logic [31:0] old_w, input logic [31:0] src,
                                        input logic [1:0] from, input logic [2:0] n,
                                        input logic [1:0] src_off);
    logic [31:0] r;
    logic [2:0]  p;
    r = old_w;
    for (int b = 0; b < 4; b++) begin
      p = {1'b0, 2'(b)} - {1'b0, from};
      if (b >= from && p < n) begin
        r[31-8*b -: 8] = src[31-8*(int'(p)+src_off) -: 8];
      end
    end
    merge = r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= sha_pkg::INIT_H[i];
      total_r     <= '0;
      fill_r      <= '0;
      full_r      <= 1'b0;
      rnd_r       <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load) begin
        logic [3:0] wi;
        logic [1:0] bo;
        logic [2:0] n0;
        wi = fill_r[5:2];
        bo = fill_r[1:0];
        n0 = (cnt > 3'd4 - {1'b0, bo}) ? 3'd4 - {1'b0, bo} : cnt;
        total_r <= total_r + 61'(cnt);
        w_r[wi] <= merge(w_r[wi], in_item.data_word, bo, n0, 2'd0);
        if (cnt > n0) begin
          // Bytes past a full block wait until the block has been compressed.
          if (fill_sum[6]) begin
            spill_r <= merge(32'd0, in_item.data_word, 2'd0, cnt - n0, n0[1:0]);
          end else begin
            w_r[4'(wi + 4'd1)] <= merge(w_r[4'(wi + 4'd1)], in_item.data_word, 2'd0,
                                        cnt - n0, n0[1:0]);
          end
        end
        fill_r <= fill_sum[5:0];
      end
      if (cmd.pad) begin
        // First pad step appends 0x80, later ones write zero bytes to a word edge.
        logic [31:0] pw;
        logic [3:0]  wi;
        pw = w_r[fill_r[5:2]];
        wi = fill_r[5:2];
        for (int b = 0; b < 4; b++) begin
          if (2'(b) >= fill_r[1:0]) pw[31-8*b -: 8] = 8'h00;
        end
        if (!full_r && !total_pad_r) pw[31-8*fill_r[1:0] -: 8] = sha_pkg::PAD_BYTE;
        w_r[wi] <= pw;
        fill_r  <= {fill_r[5:2] + 4'd1, 2'b00};
        if (wi == 4'd15) full_r <= 1'b1;
      end
      if (cmd.len) begin
        w_r[14] <= bits[63:32];
        w_r[15] <= bits[31:0];
      end
      if (cmd.init_vars) begin
        for (int i = 0; i < 8; i++) var_r[i] <= chain_r[i];
        rnd_r <= '0;
      end
      if (cmd.round) begin
        var_r[7] <= var_r[6]; var_r[6] <= var_r[5]; var_r[5] <= var_r[4];
        var_r[4] <= var_r[3] + t1;
        var_r[3] <= var_r[2]; var_r[2] <= var_r[1]; var_r[1] <= var_r[0];
        var_r[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        rnd_r   <= rnd_r + 6'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + var_r[i];
        // The full flag clears, and a block filled by padding leaves an empty buffer.
        full_r <= full_r && !total_pad_r ? 1'b1 : 1'b0;
        if (full_r) fill_r <= '0;
        // Any bytes that ran past the old block start the new one.
        w_r[0] <= spill_r;
        emit_r <= '0;
      end
      if (cmd.emit) begin
        out_r       <= {chain_r[emit_r], emit_r == 3'd7};
        emit_r      <= emit_r + 3'd1;
      end
      if (cmd.reinit) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= sha_pkg::INIT_H[i];
        total_r <= '0;
        fill_r  <= '0;
        full_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_pad_r <= 1'b0;
    end else if (cmd.reinit || cmd.load) begin
      total_pad_r <= 1'b0;
    end else if (cmd.pad) begin
      total_pad_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_ALWAYS(a_one_cmd, clk, rst_n, $countones({cmd.load, cmd.pad, cmd.round, cmd.emit}) <= 1, "overlapping commands")
  `ASSERT_NEXT(a_round_wrap, clk, rst_n, cmd.round && rnd_r == 6'd63, rnd_r == 6'd0, "round index wrap")

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the SHA-256 message hasher.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  sha_pkg::in_item_t  in_item;
  logic               out_valid;
  sha_pkg::out_item_t out_item;

  sha256_message_hasher DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item));

  // Software copy of the hash state.
  logic [31:0] hash_state [8];
  logic [31:0] msg_block [16];
  logic [60:0] msg_bytes;
  int          blk_fill;

  sha_pkg::in_item_t  pending_q [$];
  sha_pkg::out_item_t digest_q [$];
  int                 accepted_cnt = 0;
  int                 err_cnt = 0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 64; i++)
      w[i] = (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    msg_block[blk_fill / 4][31 - 8 * (blk_fill % 4) -: 8] = b;
    blk_fill++;
    if (blk_fill == 64) begin
      compress_msg_block();
      blk_fill = 0;
    end
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = H_INIT[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    msg_bytes = '0;
    blk_fill  = 0;
  endtask

  // Absorbs one accepted transaction and queues the digest on a last item.
  task automatic hash_item(input sha_pkg::in_item_t it);
    int                 n;
    logic [63:0]        bit_len;
    sha_pkg::out_item_t d;
    n = (it.byte_count > 4) ? 4 : it.byte_count;
    for (int i = 0; i < n; i++) begin
      absorb_byte(it.data_word[31 - 8 * i -: 8]);
      msg_bytes++;
    end
    if (it.last) begin
      bit_len = {msg_bytes, 3'b000};
      absorb_byte(8'h80);
      if (blk_fill > 56)
        while (blk_fill != 0) absorb_byte(8'h00);
      while (blk_fill < 56) absorb_byte(8'h00);
      msg_block[14] = bit_len[63:32];
      msg_block[15] = bit_len[31:0];
      compress_msg_block();
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hash_state[i];
        d.digest_last = (i == 7);
        digest_q = {digest_q, d};
      end
      restart_message();
    end
  endtask

  task automatic queue_item(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
    sha_pkg::in_item_t it;
    it.data_word  = w;
    it.byte_count = cnt;
    it.last       = lst;
    pending_q = {pending_q, it};
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: holds an item until it is taken, then idles at random, except back to back from item 180 to 269.
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
      restart_message();
    end else begin
      if (start && !busy) begin
        hash_item(in_item);
        accepted_cnt++;
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 &&
            ((accepted_cnt >= 180 && accepted_cnt < 270) || $urandom_range(99) >= 26)) begin
          start   <= 1'b1;
          in_item <= pending_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed digest word must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word, expected none, actual %h/%b",
                 $time, out_item.digest_word, out_item.digest_last);
        err_cnt++;
      end else if (out_item !== digest_q[0]) begin
        $display("%0t: digest mismatch, expected %h/%b, actual %h/%b", $time,
                 digest_q[0].digest_word, digest_q[0].digest_last,
                 out_item.digest_word, out_item.digest_last);
        err_cnt++;
        void'(digest_q.pop_front());
      end else begin
        void'(digest_q.pop_front());
      end
    end
  end

  initial begin
    int msg_items;
    int cnt;

    // Directed: empty message, "abc", oversized counts, short and empty items.
    queue_item(32'hffffffff, 3'd0, 1'b1);
    queue_item(32'h61626300, 3'd3, 1'b1);
    queue_item(32'hdeadbeef, 3'd5, 1'b1);
    queue_item(32'h01234567, 3'd6, 1'b0);
    queue_item(32'h89abcdef, 3'd7, 1'b0);
    queue_item(32'hffffffff, 3'd0, 1'b0);
    queue_item(32'h00000000, 3'd2, 1'b0);
    queue_item(32'h55aa55aa, 3'd1, 1'b0);
    queue_item(32'h00000000, 3'd0, 1'b1);
    // 56 bytes: the length field no longer fits, so padding takes two blocks.
    for (int i = 0; i < 14; i++)
      queue_item((i % 2) ? 32'hffffffff : 32'h00000000, 3'd4, i == 13);

    // Random messages, mostly whole words, a few short, empty or oversized items.
    while (pending_q.size() < 420) begin
      msg_items = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(20);
      for (int i = 0; i <= msg_items; i++) begin
        cnt = ($urandom_range(9) < 8) ? 4 : $urandom_range(7);
        if (i == msg_items && $urandom_range(1)) cnt = $urandom_range(4);
        queue_item($urandom, cnt[2:0], i == msg_items);
      end
    end

    do @(posedge clk); while (pending_q.size() > 0 || start);
    do @(posedge clk); while (digest_q.size() > 0);
    repeat (200) @(posedge clk);
    if (err_cnt == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
